/* src/tfpc_pkg.sv */
package tfpc_pkg;

  localparam int unsigned TimeW = 16;
  localparam int unsigned PctW = 7;
  localparam int unsigned ProdW = 23;
  localparam int unsigned MulSteps = 7;
  localparam int unsigned DivSteps = 23;
  localparam int unsigned CntW = 5;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [TimeW-1:0] DefaultOpenMs = 16'd6000;
  localparam logic [TimeW-1:0] DefaultCloseMs = 16'd6000;
  localparam logic [TimeW-1:0] TimeMax = 16'hFFFF;
  localparam logic [PctW-1:0] PctFull = 7'd100;
  localparam logic [7:0] SwipeMark = 8'hFF;

  typedef enum logic [1:0] {
    MODE_HOMING = 2'd0,
    MODE_IDLE = 2'd1,
    MODE_OPENING = 2'd2,
    MODE_CLOSING = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_SET = 2'd1,
    FUNC_SWIPE_OPEN = 2'd2,
    FUNC_SWIPE_CLOSE = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OPEN_TRAVEL = 3'd0,
    REG_CLOSE_TRAVEL = 3'd1,
    REG_SWIPE = 3'd2,
    REG_END_STOP = 3'd3,
    REG_HOMING = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_CALC,
    ST_COMMIT
  } st_e;

  typedef struct packed {
    logic start;
    logic [TimeW-1:0] mul_a;
    logic [PctW-1:0] mul_b;
    logic [TimeW-1:0] divisor;
  } md_req_t;

  typedef struct packed {
    logic done;
    logic [ProdW-1:0] quot;
  } md_rsp_t;

endpackage

/* src/tfpc_if.sv */
interface tfpc_item_if;
  logic valid;
  logic ready;
  logic [1:0] func;
  logic [7:0] position;
  modport source (output valid, func, position, input ready);
  modport sink (input valid, func, position, output ready);
endinterface

interface tfpc_result_if;
  logic valid;
  logic ready;
  logic open_drive;
  logic close_drive;
  logic [6:0] position_now;
  logic position_known;
  logic [1:0] mode;
  modport source (output valid, open_drive, close_drive, position_now, position_known, mode,
                  input ready);
  modport sink (input valid, open_drive, close_drive, position_now, position_known, mode,
                output ready);
endinterface

interface tfpc_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/tfpc_muldiv.sv */
module tfpc_muldiv (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tfpc_pkg::md_req_t req_i,
  output tfpc_pkg::md_rsp_t rsp_o
);
  import tfpc_pkg::*;

  md_state_e md_q, md_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [ProdW-1:0] acc_q, acc_d;
  logic [TimeW-1:0] a_q, a_d;
  logic [PctW-1:0] b_q, b_d;
  logic [TimeW-1:0] dv_q, dv_d;
  logic [TimeW-1:0] rem_q, rem_d;
  logic done_q, done_d;
  logic [TimeW:0] rs;
  logic [TimeW:0] diff;
  logic ge;

  assign rs = {rem_q, acc_q[ProdW-1]};
  assign diff = rs - {1'b0, dv_q};
  assign ge = (rs >= {1'b0, dv_q});

  always_comb begin
    md_d = md_q;
    unique case (md_q)
      MD_IDLE: if (req_i.start) md_d = MD_MUL;
      MD_MUL: if (cnt_q == '0) md_d = MD_DIV;
      MD_DIV: if (cnt_q == '0) md_d = MD_IDLE;
      default: md_d = MD_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    acc_d = acc_q;
    a_d = a_q;
    b_d = b_q;
    dv_d = dv_q;
    rem_d = rem_q;
    done_d = 1'b0;
    unique case (md_q)
      MD_IDLE: begin
        if (req_i.start) begin
          acc_d = '0;
          a_d = req_i.mul_a;
          b_d = req_i.mul_b;
          dv_d = req_i.divisor;
          cnt_d = CntW'(MulSteps - 1);
        end
      end
      MD_MUL: begin
        acc_d = {acc_q[ProdW-2:0], 1'b0} + (b_q[PctW-1] ? {{(ProdW-TimeW){1'b0}}, a_q} : '0);
        b_d = {b_q[PctW-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d = CntW'(DivSteps - 1);
          rem_d = '0;
        end
      end
      MD_DIV: begin
        rem_d = ge ? diff[TimeW-1:0] : rs[TimeW-1:0];
        acc_d = {acc_q[ProdW-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) done_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q <= MD_IDLE;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      md_q <= md_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q <= a_d;
    b_q <= b_d;
    dv_q <= dv_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q;

endmodule

/* src/timed_flap_position_controller.sv */
// A tick that needs no division goes through the START and COMMIT states to the result;
// a move start, an interrupted move or a swipe also runs the serial multiply-divide unit
// (7 multiply steps plus 23 divide steps) in the CALC state before COMMIT.
// An item is taken only in IDLE, after the last commits; COMMIT stalls on an unread result.
// Reset (asynchronous, active low) restores the register defaults and starts homing.
module timed_flap_position_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  tfpc_item_if.sink      item_i,
  tfpc_result_if.source  result_o,
  tfpc_cfg_if.sink       cfg_i
);
  import tfpc_pkg::*;

  st_e st_q, st_d;
  logic [TimeW-1:0] open_tr_q, close_tr_q, swipe_q, end_stop_q, homing_q;
  mode_e mode_q, mode_d;
  logic [PctW-1:0] cur_q, cur_d, pend_q, pend_d;
  logic [7:0] tgt_q, tgt_d;
  logic valid_q, valid_d, recal_q, recal_d;
  logic [TimeW-1:0] el_q, el_d, run_q, run_d;
  func_e func_q;
  logic [7:0] pos_q;
  logic out_valid_q;
  logic out_open_q, out_close_q, out_known_q;
  logic [PctW-1:0] out_pos_q;
  mode_e out_mode_q;

  md_req_t md_req;
  md_rsp_t md_rsp;
  logic commit;
  logic need_op;
  logic [TimeW-1:0] tr_open, tr_close;
  logic [PctW-1:0] pct_res;
  logic [PctW-1:0] p_clamp;
  logic p_end;
  logic tgt_up;
  logic [PctW-1:0] tgt_diff;

  assign tr_open = (open_tr_q == '0) ? DefaultOpenMs : open_tr_q;
  assign tr_close = (close_tr_q == '0) ? DefaultCloseMs : close_tr_q;
  assign pct_res = (md_rsp.quot > ProdW'(PctFull)) ? PctFull : md_rsp.quot[PctW-1:0];
  assign p_clamp = (pos_q > {1'b0, PctFull}) ? PctFull : pos_q[PctW-1:0];
  assign p_end = (p_clamp == '0) || (p_clamp == PctFull);
  assign tgt_up = (tgt_q > {1'b0, cur_q});
  assign tgt_diff = tgt_up ? (tgt_q[PctW-1:0] - cur_q) : (cur_q - tgt_q[PctW-1:0]);

  always_comb begin
    need_op = 1'b0;
    md_req.mul_a = swipe_q;
    md_req.mul_b = PctFull;
    md_req.divisor = tr_open;
    case (func_q)
      FUNC_TICK: begin
        need_op = (mode_q == MODE_IDLE) && (tgt_q != {1'b0, cur_q}) &&
                  (tgt_q <= {1'b0, PctFull}) && (tgt_q != '0) && (tgt_q != {1'b0, PctFull});
        md_req.mul_a = tgt_up ? tr_open : tr_close;
        md_req.mul_b = tgt_diff;
        md_req.divisor = TimeW'(PctFull);
      end
      FUNC_SET: begin
        need_op = (mode_q == MODE_OPENING || mode_q == MODE_CLOSING) && !recal_q &&
                  valid_q && ({1'b0, p_clamp} != tgt_q) && (tgt_q <= {1'b0, PctFull});
        md_req.mul_a = (el_q > run_q) ? run_q : el_q;
        md_req.divisor = (mode_q == MODE_OPENING) ? tr_open : tr_close;
      end
      FUNC_SWIPE_OPEN: need_op = (mode_q != MODE_HOMING);
      default: begin
        need_op = (mode_q != MODE_HOMING);
        md_req.divisor = tr_close;
      end
    endcase
  end

  assign md_req.start = (st_q == ST_START) && need_op;

  tfpc_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (item_i.valid) st_d = ST_START;
      ST_START: st_d = need_op ? ST_CALC : ST_COMMIT;
      ST_CALC: if (md_rsp.done) st_d = ST_COMMIT;
      ST_COMMIT: if (commit) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  assign commit = (st_q == ST_COMMIT) && (!out_valid_q || result_o.ready);
  assign item_i.ready = (st_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  always_comb begin
    logic [TimeW-1:0] el_inc;
    logic fin;
    logic [PctW:0] sum;
    el_inc = (el_q == TimeMax) ? el_q : el_q + 1'b1;
    fin = 1'b0;
    sum = '0;
    mode_d = mode_q;
    cur_d = cur_q;
    pend_d = pend_q;
    tgt_d = tgt_q;
    valid_d = valid_q;
    recal_d = recal_q;
    el_d = el_q;
    run_d = run_q;
    case (func_q)
      FUNC_TICK: begin
        el_d = el_inc;
        if (mode_q == MODE_HOMING) begin
          if (el_inc >= homing_q) begin
            cur_d = '0;
            tgt_d = '0;
            valid_d = 1'b1;
            mode_d = MODE_IDLE;
          end
        end else if (mode_q == MODE_IDLE) begin
          if (tgt_q != {1'b0, cur_q} && tgt_q <= {1'b0, PctFull}) begin
            mode_d = tgt_up ? MODE_OPENING : MODE_CLOSING;
            if (tgt_q == '0 || tgt_q == {1'b0, PctFull}) begin
              run_d = end_stop_q;
            end else begin
              run_d = md_rsp.quot[TimeW-1:0];
            end
            el_d = '0;
          end
        end else if (el_inc >= run_q) begin
          mode_d = MODE_IDLE;
          if (recal_q) begin
            cur_d = PctFull;
            valid_d = 1'b1;
            recal_d = 1'b0;
            tgt_d = {1'b0, pend_q};
          end else if (tgt_q <= {1'b0, PctFull}) begin
            cur_d = tgt_q[PctW-1:0];
            if (tgt_q == '0 || tgt_q == {1'b0, PctFull}) valid_d = 1'b1;
          end
        end
      end
      FUNC_SET: begin
        if (mode_q != MODE_HOMING) begin
          if (recal_q) begin
            if (p_end) begin
              recal_d = 1'b0;
              cur_d = '0;
              mode_d = MODE_IDLE;
            end else begin
              pend_d = p_clamp;
              fin = 1'b1;
            end
          end
          if (!fin && !valid_q && !p_end) begin
            mode_d = MODE_IDLE;
            cur_d = '0;
            pend_d = p_clamp;
            recal_d = 1'b1;
            tgt_d = {1'b0, PctFull};
            fin = 1'b1;
          end
          if (!fin && {1'b0, p_clamp} == tgt_q) fin = 1'b1;
          if (!fin) begin
            if (mode_d != MODE_IDLE) begin
              if (tgt_q <= {1'b0, PctFull} && valid_q) begin
                if (mode_d == MODE_OPENING) begin
                  sum = {1'b0, cur_d} + {1'b0, pct_res};
                  cur_d = (sum > {1'b0, PctFull}) ? PctFull : sum[PctW-1:0];
                end else begin
                  cur_d = (cur_d >= pct_res) ? cur_d - pct_res : '0;
                end
              end
              mode_d = MODE_IDLE;
            end
            tgt_d = {1'b0, p_clamp};
          end
        end
      end
      default: begin
        if (mode_q != MODE_HOMING) begin
          recal_d = 1'b0;
          if (func_q == FUNC_SWIPE_OPEN) begin
            sum = {1'b0, cur_q} + {1'b0, pct_res};
            cur_d = (sum > {1'b0, PctFull}) ? PctFull : sum[PctW-1:0];
            mode_d = MODE_OPENING;
          end else begin
            cur_d = (cur_q >= pct_res) ? cur_q - pct_res : '0;
            mode_d = MODE_CLOSING;
          end
          valid_d = 1'b0;
          tgt_d = SwipeMark;
          el_d = '0;
          run_d = swipe_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      open_tr_q <= 16'd6000;
      close_tr_q <= 16'd6000;
      swipe_q <= 16'd500;
      end_stop_q <= 16'd6200;
      homing_q <= 16'd7000;
      mode_q <= MODE_HOMING;
      cur_q <= '0;
      pend_q <= '0;
      tgt_q <= '0;
      valid_q <= 1'b0;
      recal_q <= 1'b0;
      el_q <= '0;
      run_q <= 16'd7000;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_OPEN_TRAVEL: open_tr_q <= cfg_i.data;
          REG_CLOSE_TRAVEL: close_tr_q <= cfg_i.data;
          REG_SWIPE: swipe_q <= cfg_i.data;
          REG_END_STOP: end_stop_q <= cfg_i.data;
          REG_HOMING: homing_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (commit) begin
        mode_q <= mode_d;
        cur_q <= cur_d;
        pend_q <= pend_d;
        tgt_q <= tgt_d;
        valid_q <= valid_d;
        recal_q <= recal_d;
        el_q <= el_d;
        run_q <= run_d;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      func_q <= func_e'(item_i.func);
      pos_q <= item_i.position;
    end
    if (commit) begin
      out_open_q <= (mode_d == MODE_OPENING);
      out_close_q <= (mode_d == MODE_CLOSING) || (mode_d == MODE_HOMING);
      out_pos_q <= cur_d;
      out_known_q <= valid_d;
      out_mode_q <= mode_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.open_drive = out_open_q;
  assign result_o.close_drive = out_close_q;
  assign result_o.position_now = out_pos_q;
  assign result_o.position_known = out_known_q;
  assign result_o.mode = out_mode_q;

`ifndef NO_ASSERTIONS
  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> st_q == ST_CALC)
    else $error("divider finished outside of a calculation");
  a_commit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> st_q == ST_IDLE && out_valid_q)
    else $error("commit did not load the result register");
  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= PctFull && pend_q <= PctFull)
    else $error("position estimate out of range");
  a_recal_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recal_q |-> !valid_q)
    else $error("recalibration while the position is known");
`endif

endmodule

/* verif/tfpc_checker.sv */
module tfpc_checker
  import tfpc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  tfpc_item_if    item_mon,
  tfpc_result_if  result_mon,
  tfpc_cfg_if     cfg_mon,
  output int      fail_count_o,
  output int      outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       open_drive;
    logic       close_drive;
    logic [6:0] position_now;
    logic       position_known;
    logic [1:0] mode;
  } flap_status_t;

  flap_status_t status_q[$];

  logic [15:0] open_travel, close_travel, swipe_len, end_stop_len, homing_len;
  mode_e       run_mode;
  logic [6:0]  cur_pct;
  logic [7:0]  tgt_pct;
  logic [6:0]  pend_pct;
  logic        known, recal;
  logic [15:0] elapsed, run_len;

  function automatic int travel_of(mode_e dir);
    if (dir == MODE_OPENING) return (open_travel != 0) ? open_travel : DefaultOpenMs;
    return (close_travel != 0) ? close_travel : DefaultCloseMs;
  endfunction

  function automatic int pct_after(int travel, longint ms);
    longint m;
    m = (ms * 100) / travel;
    return (m > 100) ? 100 : int'(m);
  endfunction

  function automatic void flap_tick();
    int diff;
    if (elapsed != TimeMax) elapsed++;
    if (run_mode == MODE_HOMING) begin
      if (elapsed >= homing_len) begin
        cur_pct = 0;
        tgt_pct = 0;
        known = 1'b1;
        run_mode = MODE_IDLE;
      end
      return;
    end
    if (run_mode == MODE_IDLE) begin
      if (tgt_pct == {1'b0, cur_pct} || tgt_pct > 100) return;
      if (tgt_pct > cur_pct) begin
        diff = tgt_pct - cur_pct;
        run_mode = MODE_OPENING;
      end else begin
        diff = cur_pct - tgt_pct;
        run_mode = MODE_CLOSING;
      end
      if (tgt_pct == 0 || tgt_pct == 100) run_len = end_stop_len;
      else run_len = 16'((diff * travel_of(run_mode)) / 100);
      elapsed = 0;
      return;
    end
    if (elapsed >= run_len) begin
      run_mode = MODE_IDLE;
      if (recal) begin
        cur_pct = 100;
        known = 1'b1;
        recal = 1'b0;
        tgt_pct = {1'b0, pend_pct};
      end else if (tgt_pct <= 100) begin
        cur_pct = tgt_pct[6:0];
        if (tgt_pct == 0 || tgt_pct == 100) known = 1'b1;
      end
    end
  endfunction

  function automatic void flap_set(logic [7:0] req);
    logic [7:0] pos;
    longint     el;
    int         moved;
    int         sum;
    if (run_mode == MODE_HOMING) return;
    pos = (req > 100) ? 8'd100 : req;
    if (recal) begin
      if (pos == 0 || pos == 100) begin
        recal = 1'b0;
        cur_pct = 0;
        run_mode = MODE_IDLE;
      end else begin
        pend_pct = pos[6:0];
        return;
      end
    end
    if (!known && pos != 0 && pos != 100) begin
      run_mode = MODE_IDLE;
      cur_pct = 0;
      pend_pct = pos[6:0];
      recal = 1'b1;
      tgt_pct = 100;
      return;
    end
    if (pos == tgt_pct) return;
    if (run_mode != MODE_IDLE) begin
      if (tgt_pct <= 100 && known) begin
        el = (elapsed > run_len) ? run_len : elapsed;
        moved = pct_after(travel_of(run_mode), el);
        if (run_mode == MODE_OPENING) begin
          sum = cur_pct + moved;
          cur_pct = (sum > 100) ? 7'd100 : 7'(sum);
        end else begin
          cur_pct = (cur_pct >= moved) ? 7'(cur_pct - moved) : 7'd0;
        end
      end
      run_mode = MODE_IDLE;
    end
    tgt_pct = pos;
  endfunction

  function automatic void flap_swipe(mode_e dir);
    int delta;
    int sum;
    if (run_mode == MODE_HOMING) return;
    recal = 1'b0;
    delta = pct_after(travel_of(dir), swipe_len);
    if (dir == MODE_OPENING) begin
      sum = cur_pct + delta;
      cur_pct = (sum > 100) ? 7'd100 : 7'(sum);
    end else begin
      cur_pct = (cur_pct >= delta) ? 7'(cur_pct - delta) : 7'd0;
    end
    known = 1'b0;
    tgt_pct = SwipeMark;
    run_mode = dir;
    elapsed = 0;
    run_len = swipe_len;
  endfunction

  function automatic flap_status_t flap_status();
    flap_status_t s;
    s.open_drive = (run_mode == MODE_OPENING);
    s.close_drive = (run_mode == MODE_CLOSING || run_mode == MODE_HOMING);
    s.position_now = cur_pct;
    s.position_known = known;
    s.mode = run_mode;
    return s;
  endfunction

  task automatic compare_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
      fail_count_o++;
    end
  endtask

  assign outstanding_o = status_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    flap_status_t exp_s;
    if (!rst_ni) begin
      open_travel = 6000;
      close_travel = 6000;
      swipe_len = 500;
      end_stop_len = 6200;
      homing_len = 7000;
      run_mode = MODE_HOMING;
      cur_pct = 0;
      tgt_pct = 0;
      pend_pct = 0;
      known = 1'b0;
      recal = 1'b0;
      elapsed = 0;
      run_len = 7000;
      fail_count_o = 0;
      status_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_e'(cfg_mon.index))
          REG_OPEN_TRAVEL:  open_travel = cfg_mon.data;
          REG_CLOSE_TRAVEL: close_travel = cfg_mon.data;
          REG_SWIPE:        swipe_len = cfg_mon.data;
          REG_END_STOP:     end_stop_len = cfg_mon.data;
          REG_HOMING:       homing_len = cfg_mon.data;
          default: ;
        endcase
      end
      if (result_mon.valid && result_mon.ready) begin
        if (status_q.size() == 0) begin
          $error("result transaction with no expected status waiting");
          fail_count_o++;
        end else begin
          exp_s = status_q.pop_front();
          compare_field("open_drive", exp_s.open_drive, result_mon.open_drive);
          compare_field("close_drive", exp_s.close_drive, result_mon.close_drive);
          compare_field("position_now", exp_s.position_now, result_mon.position_now);
          compare_field("position_known", exp_s.position_known, result_mon.position_known);
          compare_field("mode", exp_s.mode, result_mon.mode);
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        case (func_e'(item_mon.func))
          FUNC_TICK:        flap_tick();
          FUNC_SET:         flap_set(item_mon.position);
          FUNC_SWIPE_OPEN:  flap_swipe(MODE_OPENING);
          FUNC_SWIPE_CLOSE: flap_swipe(MODE_CLOSING);
          default: ;
        endcase
        status_q.push_back(flap_status());
      end
    end
  end
endmodule

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tfpc_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   outstanding;
  int   burst_left = 0;
  bit   fast_mode = 1'b0;
  int   stall_pct = 0;
  int   stall_phase = 0;

  tfpc_item_if   item_ch ();
  tfpc_result_if result_ch ();
  tfpc_cfg_if    cfg_ch ();

  timed_flap_position_controller dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  tfpc_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_mon      (item_ch),
    .result_mon    (result_ch),
    .cfg_mon       (cfg_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    item_ch.valid = 1'b0;
    item_ch.func = FUNC_TICK;
    item_ch.position = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_OPEN_TRAVEL;
    cfg_ch.data = '0;
    result_ch.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 300 == 0) stall_pct <= $urandom_range(0, 3) * 25;
    if (fast_mode || stall_pct == 0) result_ch.ready <= 1'b1;
    else result_ch.ready <= ($urandom_range(1, 100) > stall_pct);
  end

  task automatic send_item(func_e f, logic [7:0] pos);
    if (!fast_mode && burst_left == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    item_ch.valid <= 1'b1;
    item_ch.func <= f;
    item_ch.position <= pos;
    do @(posedge clk_i); while (!item_ch.ready);
  endtask

  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [15:0] op, logic [15:0] cl, logic [15:0] sw,
                           logic [15:0] es, logic [15:0] hm);
    write_reg(REG_OPEN_TRAVEL, op);
    write_reg(REG_CLOSE_TRAVEL, cl);
    write_reg(REG_SWIPE, sw);
    write_reg(REG_END_STOP, es);
    write_reg(REG_HOMING, hm);
  endtask

  task automatic ticks(int n);
    repeat (n) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic random_items(int n);
    int r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 78) send_item(FUNC_TICK, 8'($urandom_range(0, 255)));
      else if (r < 84) send_item(FUNC_SET, ($urandom_range(0, 1) != 0) ? 8'd100 : 8'd0);
      else if (r < 92) send_item(FUNC_SET, 8'($urandom_range(0, 255)));
      else if (r < 96) send_item(FUNC_SWIPE_OPEN, 8'($urandom_range(0, 255)));
      else send_item(FUNC_SWIPE_CLOSE, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    #20_000_000;
    $display("FAIL timed_flap_position_controller");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_all(16'd200, 16'd300, 16'd50, 16'd40, 16'd5);

    send_item(FUNC_SET, 8'd50);
    send_item(FUNC_SWIPE_OPEN, 8'd0);
    ticks(6);
    send_item(FUNC_SET, 8'd60);
    ticks(5);
    send_item(FUNC_SET, 8'd255);
    ticks(3);
    send_item(FUNC_SWIPE_OPEN, 8'hFF);
    send_item(FUNC_SET, 8'd30);
    ticks(2);
    send_item(FUNC_SET, 8'd70);
    send_item(FUNC_SET, 8'd100);
    send_item(FUNC_SWIPE_CLOSE, 8'hAA);
    send_item(FUNC_SET, 8'd0);
    send_item(FUNC_SET, 8'd101);
    ticks(45);
    drain();

    random_items(140);
    drain();

    write_all(16'd0, 16'd0, 16'd65535, 16'd0, 16'd65535);
    random_items(130);
    drain();

    write_all(16'd65535, 16'd1, 16'd1, 16'd65535, 16'd0);
    fast_mode = 1'b1;
    send_item(FUNC_SET, 8'd0);
    ticks(2);
    send_item(FUNC_SET, 8'd100);
    ticks(20);
    fast_mode = 1'b0;
    random_items(100);
    drain();

    write_all(16'd37, 16'd120, 16'd300, 16'd20, 16'd7000);
    random_items(100);
    drain();

    if (fail_count == 0) begin
      $display("PASS timed_flap_position_controller");
    end else begin
      $display("FAIL timed_flap_position_controller");
    end
    $finish;
  end
endmodule
